// ===== hw/rtl/bjct_pkg.sv =====
// ----------------------------------------------------------------------------
// Block jump count table package
// Shared field widths, request and response types and the packed table entry.
// ----------------------------------------------------------------------------
package bjct_pkg;

   localparam int unsigned POS_W = 10;
   localparam int unsigned CNT_W = 11;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic {
      OP_SET   = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic {
      CSR_USED_POSITIONS = 1'b0,
      CSR_BLOCK_LENGTH   = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type           operation;
      logic [POS_W-1:0] position;
      logic [CNT_W-1:0] jump_length;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] final_position;
      logic [CNT_W-1:0] jump_count;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] steps;
      logic [CNT_W-1:0] target;
      logic [POS_W-1:0] last;
   } entry_type;

endpackage

// ===== hw/rtl/bjct_ram.sv =====
// ----------------------------------------------------------------------------
// Block jump count table RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bjct_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/block_jump_count_table_unit.sv =====
// ----------------------------------------------------------------------------
// Block jump count table unit
// Square-root decomposition jump table: set requests store a jump and rebuild
// the block entries below it, query requests walk block exits to the end.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  req       in         req_valid/req_stall  req_data (req_type)
//  rsp       out        rsp_valid/rsp_stall  rsp_data (rsp_type)
//  csr       in         csr_we               csr_index, csr_data
//
//  A set request writes its jump and finds its block start by a serial
//  divider, then reads its jump and rebuilds each position from it down to
//  the block start, reading the entry further on where the jump stays inside
//  the block. A query request follows one block exit per entry read until
//  the walk ends, then loads the response.
//  One request is worked on at a time; the response register lets the next
//  request enter while a response waits. Reset clears control state only.
module block_jump_count_table_unit
   import bjct_pkg::*;
#(
   parameter int unsigned MAX_POSITIONS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  csr_index_type        csr_index,
   input  logic [CNT_W-1:0]     csr_data
);

   localparam int unsigned AW    = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
   localparam int unsigned DIV_W = $clog2(POS_W);
   localparam int unsigned EW    = $bits(entry_type);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_DIV  = 7'b0000010,
      S_RJA  = 7'b0000100,
      S_RJD  = 7'b0001000,
      S_RBD  = 7'b0010000,
      S_QRD  = 7'b0100000,
      S_QEV  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic               out_pend_ff, out_pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]   blen_ff, blen_in;
   logic [POS_W-1:0]   p_ff, p_in;
   logic [DIV_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [POS_W-1:0]   start_ff, start_in;
   logic [CNT_W:0]     blk_end_ff, blk_end_in;
   logic [POS_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   cur_ff, cur_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [POS_W-1:0]   lst_ff, lst_in;

   logic [CNT_W-1:0]   n_eff;
   logic [CNT_W-1:0]   len_eff;
   logic               req_fire;
   logic               rsp_free;

   logic               j_we;
   logic [AW-1:0]      j_waddr, j_raddr;
   logic [CNT_W-1:0]   j_wdata, j_rdata;
   logic               b_we;
   logic [AW-1:0]      b_waddr, b_raddr;
   entry_type          b_wdata, b_rdata;

   logic [CNT_W:0]     rem_cat;
   logic [CNT_W-1:0]   rem_next;
   logic [CNT_W-1:0]   j_eff;
   logic [CNT_W:0]     t_wide;
   logic [CNT_W:0]     sum_wide;
   logic [CNT_W-1:0]   steps_sat;

   bjct_ram #(.WIDTH(CNT_W), .DEPTH(MAX_POSITIONS)) u_jump_ram (
      .clock (clock),
      .we    (j_we),
      .waddr (j_waddr),
      .wdata (j_wdata),
      .raddr (j_raddr),
      .rdata (j_rdata)
   );

   bjct_ram #(.WIDTH(EW), .DEPTH(MAX_POSITIONS)) u_entry_ram (
      .clock (clock),
      .we    (b_we),
      .waddr (b_waddr),
      .wdata (b_wdata),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   assign n_eff     = (32'(used_ff) > MAX_POSITIONS) ? CNT_W'(MAX_POSITIONS) : used_ff;
   assign len_eff   = (blen_ff == '0) ? CNT_W'(1) : blen_ff;
   assign req_stall = (state_ff != S_IDLE) || out_pend_ff;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rem_cat  = {rem_ff, p_ff[div_cnt_ff]};
   assign rem_next = (rem_cat >= {1'b0, len_eff}) ? CNT_W'(rem_cat - {1'b0, len_eff})
                                                  : CNT_W'(rem_cat);
   assign j_eff     = (j_rdata == '0) ? CNT_W'(1) : j_rdata;
   assign t_wide    = (CNT_W+1)'(i_ff) + (CNT_W+1)'(j_eff);

   always_comb begin
      sum_wide  = '0;
      steps_sat = '0;
      unique case (state_ff)
         S_QEV: begin
            sum_wide = (CNT_W+1)'(cnt_ff) + (CNT_W+1)'(b_rdata.steps);
         end
         default: begin
            sum_wide = (CNT_W+1)'(b_rdata.steps) + (CNT_W+1)'(1);
         end
      endcase
      steps_sat = (sum_wide > (CNT_W+1)'(CNT_MAX)) ? CNT_MAX : CNT_W'(sum_wide);
   end

   always_comb begin
      state_in     = state_ff;
      out_pend_in  = out_pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      used_in      = used_ff;
      blen_in      = blen_ff;
      p_in         = p_ff;
      div_cnt_in   = div_cnt_ff;
      rem_in       = rem_ff;
      start_in     = start_ff;
      blk_end_in   = blk_end_ff;
      i_in         = i_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      lst_in       = lst_ff;
      j_we         = 1'b0;
      j_waddr      = AW'(req_data.position);
      j_wdata      = req_data.jump_length;
      j_raddr      = (state_ff == S_RJA) ? AW'(i_ff) : AW'(i_ff - POS_W'(1));
      b_we         = 1'b0;
      b_waddr      = AW'(i_ff);
      b_wdata      = b_rdata;
      b_raddr      = AW'(cur_ff);

      if (csr_we) begin
         unique case (csr_index)
            CSR_USED_POSITIONS: used_in = csr_data;
            CSR_BLOCK_LENGTH:   blen_in = csr_data;
            default:            used_in = used_ff;
         endcase
      end

      if (out_pend_ff && rsp_free) begin
         out_pend_in               = 1'b0;
         rsp_valid_in              = 1'b1;
         rsp_data_in.final_position = CNT_W'(lst_ff) + CNT_W'(1);
         rsp_data_in.jump_count     = cnt_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               p_in   = req_data.position;
               lst_in = req_data.position;
               cur_in = CNT_W'(req_data.position);
               cnt_in = '0;
               if (req_data.operation == OP_SET) begin
                  if (32'(req_data.position) < MAX_POSITIONS) begin
                     j_we       = 1'b1;
                     div_cnt_in = DIV_W'(POS_W - 1);
                     rem_in     = '0;
                     state_in   = S_DIV;
                  end
               end else if (CNT_W'(req_data.position) >= n_eff) begin
                  out_pend_in = 1'b1;
               end else begin
                  state_in = S_QRD;
               end
            end
         end
         S_DIV: begin
            rem_in     = rem_next;
            div_cnt_in = div_cnt_ff - DIV_W'(1);
            if (div_cnt_ff == '0) begin
               start_in   = p_ff - POS_W'(rem_next);
               blk_end_in = (CNT_W+1)'(p_ff - POS_W'(rem_next)) + (CNT_W+1)'(len_eff);
               i_in       = p_ff;
               state_in   = S_RJA;
            end
         end
         S_RJA: begin
            state_in = S_RJD;
         end
         S_RJD: begin
            if (t_wide >= (CNT_W+1)'(n_eff) || t_wide >= blk_end_ff) begin
               b_we           = 1'b1;
               b_wdata.steps  = CNT_W'(1);
               b_wdata.target = (t_wide >= (CNT_W+1)'(n_eff)) ? n_eff : CNT_W'(t_wide);
               b_wdata.last   = i_ff;
               if (i_ff == start_ff) begin
                  state_in = S_IDLE;
               end else begin
                  i_in = i_ff - POS_W'(1);
               end
            end else begin
               b_raddr  = AW'(t_wide);
               state_in = S_RBD;
            end
         end
         S_RBD: begin
            b_we          = 1'b1;
            b_wdata.steps = steps_sat;
            if (i_ff == start_ff) begin
               state_in = S_IDLE;
            end else begin
               i_in     = i_ff - POS_W'(1);
               state_in = S_RJD;
            end
         end
         S_QRD: begin
            state_in = S_QEV;
         end
         S_QEV: begin
            cnt_in = steps_sat;
            lst_in = b_rdata.last;
            if (b_rdata.target <= cur_ff || b_rdata.target >= n_eff) begin
               out_pend_in = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cur_in  = b_rdata.target;
               b_raddr = AW'(b_rdata.target);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= CNT_W'(1024);
         blen_ff      <= CNT_W'(32);
      end else begin
         state_ff     <= state_in;
         out_pend_ff  <= out_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         blen_ff      <= blen_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      p_ff        <= p_in;
      div_cnt_ff  <= div_cnt_in;
      rem_ff      <= rem_in;
      start_ff    <= start_in;
      blk_end_ff  <= blk_end_in;
      i_ff        <= i_in;
      cur_ff      <= cur_in;
      cnt_ff      <= cnt_in;
      lst_ff      <= lst_in;
   end

   a_rebuild_in_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RJD || state_ff == S_RBD) |-> (i_ff >= start_ff))
      else $error("Rebuild index has left its block.");

   a_entry_write_on_set: assert property (@(posedge clock) disable iff (reset)
      b_we |-> (state_ff == S_RJD || state_ff == S_RBD))
      else $error("Entry memory written outside a set request.");

   a_walk_inside_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QEV) |-> (cur_ff < n_eff))
      else $error("Query walk has passed the table end.");

   a_rsp_from_pending: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(out_pend_ff))
      else $error("Response raised without a finished query.");

endmodule

// ===== bench/block_jump_count_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Block jump count table unit testbench
// Fills the whole table, runs directed set and query requests, then sweeps
// random requests over several register settings with random idling on both
// channels. Every response is checked against a predictor of the table.
// ----------------------------------------------------------------------------
module block_jump_count_table_unit_tb;
   import bjct_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_POS         = 1024;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned WATCHDOG_LIMIT  = 20000;
   localparam int unsigned PLAN_PHASES     = 12;

   logic          clock;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_we    = 1'b0;
   csr_index_type csr_index = CSR_USED_POSITIONS;
   logic [CNT_W-1:0] csr_data = '0;

   logic [CNT_W-1:0] used_count = 11'd1024;
   logic [CNT_W-1:0] blk_size   = 11'd32;
   logic [CNT_W-1:0] jump_of   [MAX_POS];
   logic [CNT_W-1:0] hops_out  [MAX_POS];
   logic [CNT_W-1:0] exit_at   [MAX_POS];
   logic [POS_W-1:0] last_seen [MAX_POS];

   req_type     req_backlog[$];
   rsp_type     pending_answers[$];
   int unsigned gap_left      = 0;
   int unsigned stall_left    = 0;
   int unsigned hold_off_asks = 0;
   int unsigned hold_off_seen = 0;
   int unsigned quiet_cycles  = 0;
   bit          steady        = 1'b0;
   int unsigned n_sets        = 0;
   int unsigned n_queries     = 0;
   int unsigned n_checked     = 0;
   int unsigned n_settings    = 0;
   int unsigned errors        = 0;

   int unsigned plan_used  [PLAN_PHASES] = '{1024, 1024, 1000, 500, 2047, 1024,
                                             37, 0, 1024, 700, 64, 1024};
   int unsigned plan_len   [PLAN_PHASES] = '{32, 1, 31, 23, 45, 1024,
                                             6, 0, 0, 2047, 8, 32};
   int unsigned plan_items [PLAN_PHASES] = '{120, 20, 80, 60, 50, 10,
                                             40, 10, 15, 10, 40, 45};

   block_jump_count_table_unit #(
      .MAX_POSITIONS(MAX_POS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned sat_sum(int unsigned a, int unsigned b);
      int unsigned s;
      s = a + b;
      return (s > CNT_MAX) ? CNT_MAX : s;
   endfunction

   function automatic int unsigned idle_span();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic void predict_table_request(req_type r);
      int unsigned n, len, first, i, k, j, t, cur, lst, cnt, tgt;
      rsp_type     ans;
      n   = (used_count > MAX_POS) ? MAX_POS : used_count;
      len = (blk_size == 0) ? 1 : blk_size;
      if (r.operation == OP_SET) begin
         n_sets++;
         jump_of[r.position] = r.jump_length;
         first = (r.position / len) * len;
         for (i = r.position + 1; i > first; i--) begin
            k = i - 1;
            j = (jump_of[k] == 0) ? 1 : jump_of[k];
            t = k + j;
            if (t >= n) begin
               hops_out[k]  = CNT_W'(1);
               exit_at[k]   = CNT_W'(n);
               last_seen[k] = POS_W'(k);
            end else if (k / len != t / len) begin
               hops_out[k]  = CNT_W'(1);
               exit_at[k]   = CNT_W'(t);
               last_seen[k] = POS_W'(k);
            end else begin
               hops_out[k]  = CNT_W'(sat_sum(1, hops_out[t]));
               exit_at[k]   = exit_at[t];
               last_seen[k] = last_seen[t];
            end
         end
      end else begin
         n_queries++;
         cur = r.position;
         lst = r.position;
         cnt = 0;
         while (cur < n) begin
            tgt = exit_at[cur];
            cnt = sat_sum(cnt, hops_out[cur]);
            lst = last_seen[cur];
            if (tgt <= cur) break;
            cur = tgt;
         end
         ans.final_position = CNT_W'(lst + 1);
         ans.jump_count     = CNT_W'(cnt);
         pending_answers.push_back(ans);
      end
   endfunction

   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall) predict_table_request(req_data);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left  <= gap_left - 1;
            end else if (req_backlog.size() > 0) begin
               req_data  <= req_backlog.pop_front();
               req_valid <= 1'b1;
               gap_left  <= idle_span();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type     want;
      int unsigned span;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected response, final_position %0d jump_count %0d",
                        $time, rsp_data.final_position, rsp_data.jump_count);
               errors++;
            end else begin
               want = pending_answers.pop_front();
               n_checked++;
               if (rsp_data.final_position !== want.final_position) begin
                  $display("%0t: final_position expected %0d actual %0d", $time,
                           want.final_position, rsp_data.final_position);
                  errors++;
               end
               if (rsp_data.jump_count !== want.jump_count) begin
                  $display("%0t: jump_count expected %0d actual %0d", $time,
                           want.jump_count, rsp_data.jump_count);
                  errors++;
               end
            end
         end
         if (hold_off_seen != hold_off_asks) begin
            hold_off_seen <= hold_off_asks;
            stall_left    <= HOLD_OFF_CYCLES;
            rsp_stall     <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else begin
            span = idle_span();
            if (span > 0) begin
               rsp_stall  <= 1'b1;
               stall_left <= span - 1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no request or response moved for %0d cycles", $time, quiet_cycles);
         $display("block_jump_count_table_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_request(op_type op, int unsigned pos, int unsigned jmp);
      req_type r;
      while (req_backlog.size() >= 3) @(negedge clock);
      r.operation   = op;
      r.position    = POS_W'(pos);
      r.jump_length = CNT_W'(jmp);
      req_backlog.push_back(r);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || pending_answers.size() != 0);
   endtask

   task automatic settle_table();
      int unsigned span_cap;
      span_cap = (blk_size == 0) ? 1 : ((blk_size > MAX_POS) ? MAX_POS : blk_size);
      wait_idle();
      repeat (2 * span_cap + 40) @(posedge clock);
   endtask

   task automatic apply_settings(int unsigned used, int unsigned len);
      settle_table();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_USED_POSITIONS;
      csr_data  <= CNT_W'(used);
      @(posedge clock);
      csr_index <= CSR_BLOCK_LENGTH;
      csr_data  <= CNT_W'(len);
      @(posedge clock);
      csr_we    <= 1'b0;
      used_count = CNT_W'(used);
      blk_size   = CNT_W'(len);
      n_settings++;
      @(negedge clock);
   endtask

   task automatic queue_random(int unsigned count, int unsigned phase);
      int unsigned n, len, idx, pos, jmp, roll;
      op_type      op;
      n   = (used_count > MAX_POS) ? MAX_POS : used_count;
      len = (blk_size == 0) ? 1 : ((blk_size > MAX_POS) ? MAX_POS : blk_size);
      for (idx = 0; idx < count; idx++) begin
         if (phase == 0 && idx == 100) hold_off_asks++;
         if ((phase == 2 && idx == count / 2) || $urandom_range(0, 199) == 0) wait_idle();
         op  = $urandom_range(0, 1) ? OP_QUERY : OP_SET;
         pos = (n > 0 && $urandom_range(0, 99) < 80) ? $urandom_range(0, n - 1)
                                                    : $urandom_range(0, MAX_POS - 1);
         roll = $urandom_range(0, 99);
         if (roll < 70)      jmp = $urandom_range(0, 2 * len);
         else if (roll < 90) jmp = $urandom_range(0, 2047);
         else begin
            case ($urandom_range(0, 3))
               0:       jmp = 0;
               1:       jmp = 1;
               2:       jmp = 1024;
               default: jmp = 2047;
            endcase
         end
         queue_request(op, pos, jmp);
      end
   endtask

   initial begin : stimulus
      int unsigned p, ph;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every jump leaves the table, so the first pass reads no entry ahead.
      for (p = 0; p < MAX_POS; p++)
         queue_request(OP_SET, p, (MAX_POS - p) + $urandom_range(0, 1023));

      queue_request(OP_SET, 5, 0);
      queue_request(OP_SET, 4, 1);
      queue_request(OP_SET, 3, 2);
      queue_request(OP_QUERY, 3, 0);
      queue_request(OP_QUERY, 0, 2047);
      queue_request(OP_SET, 31, 1);
      queue_request(OP_QUERY, 31, 0);
      queue_request(OP_SET, 1023, 2047);
      queue_request(OP_QUERY, 1023, 0);
      queue_request(OP_SET, 1023, 1);
      queue_request(OP_QUERY, 1023, 0);
      queue_request(OP_SET, 0, 1024);
      queue_request(OP_SET, 32, 31);
      queue_request(OP_QUERY, 32, 0);
      queue_request(OP_QUERY, 511, 0);

      apply_settings(37, 0);
      queue_request(OP_QUERY, 36, 0);
      queue_request(OP_QUERY, 37, 0);
      queue_request(OP_QUERY, 1023, 0);
      queue_request(OP_QUERY, 0, 0);
      queue_request(OP_SET, 36, 1);
      queue_request(OP_SET, 10, 0);
      queue_request(OP_QUERY, 10, 0);

      apply_settings(2047, 1024);
      queue_request(OP_SET, 1, 1);
      queue_request(OP_QUERY, 0, 0);

      for (ph = 0; ph < PLAN_PHASES; ph++) begin
         apply_settings(plan_used[ph], plan_len[ph]);
         steady = (ph % 3 == 1);
         queue_random(plan_items[ph], ph);
      end

      settle_table();
      if (pending_answers.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_answers.size());
         errors++;
      end
      $display("Covered %0d set and %0d query requests over %0d register settings,",
               n_sets, n_queries, n_settings);
      $display("with %0d responses checked and %0d mismatches.", n_checked, errors);
      if (errors == 0)
         $display("block_jump_count_table_unit regression: pass");
      else
         $display("block_jump_count_table_unit regression: fail");
      $finish;
   end

endmodule
